// File: hdl/awmd_pkg.sv
// Package for the alpha weighted mip downsampler: payload structs, geometry
// constants and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package awmd_pkg;
    localparam int MaxWidth  = 4096;
    localparam int MaxHeight = 4096;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 13;

    localparam logic [CfgIdxW-1:0] RegSrcWidth    = 2'd0;
    localparam logic [CfgIdxW-1:0] RegSrcHeight   = 2'd1;
    localparam logic [CfgIdxW-1:0] RegChannelCnt  = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       level_done;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic            load;      // capture texel, do store write / read
        logic            emit;      // this texel completes a block
        logic            use_top;   // top row texels take part
        logic            use_left;  // left texel takes part
        logic            done;
        logic            wr_store;
        logic [ColW-1:0] col;
        logic            clear;     // restart after a register write
        logic            start_div; // start the dividers on the captured sums
        logic            alpha_mode;
        logic [1:0]      nch_m1;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_sts;
endpackage

// File: hdl/awmd_div.sv
// Radix-2 restoring divider: 20-bit dividend by 11-bit divisor, 8-bit quotient.
// Depends on awmd_pkg only by convention; result needs 20 iterations.
`timescale 1ns / 1ps
module awmd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [19:0] i_num,
    input  logic [10:0] i_den,
    output logic        o_busy,
    output logic [7:0]  o_quot
);
    logic [19:0] r_q;
    logic [11:0] r_rem;
    logic [10:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [11:0] n_rem;
    logic        n_ge;

    always_comb begin
        n_rem = {r_rem[10:0], r_q[19]};
        n_ge  = n_rem >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd19;
            r_q    <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? (n_rem - {1'b0, r_den}) : n_rem;
            r_q   <= {r_q[18:0], n_ge};
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q[7:0];
endmodule

// File: hdl/awmd_datapath.sv
// Datapath: row store memory, left texel, channel sums and four dividers.
// Depends on awmd_pkg and awmd_div.
`timescale 1ns / 1ps
module awmd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  awmd_pkg::t_cmd    i_cmd,
    input  awmd_pkg::t_in_item i_item,
    output awmd_pkg::t_sts    o_sts,
    output logic [7:0]        o_res [4]
);
    import awmd_pkg::*;

    logic [31:0] r_store [MaxWidth];
    logic [31:0] r_top_l, r_top_r;
    logic [31:0] r_left, r_prev, r_cur;
    logic        r_use_top, r_use_left;
    logic [31:0] cur;
    logic [19:0] r_num [4];
    logic [10:0] r_den [4];
    logic [19:0] n_num [4];
    logic [10:0] n_den [4];
    logic [31:0] tx [4];
    logic [3:0]  vld;
    logic [2:0]  cnt;
    logic [9:0]  asum;
    logic [9:0]  psum [3];
    logic [17:0] wsum [3];
    logic [3:0]  busy;

    assign cur = {i_item.alpha, i_item.blue, i_item.green, i_item.red};

    // Row store: per accepted texel, a write when wr_store is set and one pair of reads (two ports read).
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (i_cmd.wr_store) begin
                r_store[i_cmd.col] <= cur;
            end
            r_top_r <= r_store[i_cmd.col];
            r_top_l <= r_store[i_cmd.col - ColW'(1)];
        end
    end

    // The texel before the current one is kept aside so the block sees it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_cmd.clear) begin
            r_left <= '0;
        end else begin
            if (i_cmd.load) begin
                r_left <= cur;
                r_prev <= r_left;
                r_cur  <= cur;
                if (i_cmd.emit) begin
                    r_use_top  <= i_cmd.use_top;
                    r_use_left <= i_cmd.use_left;
                end
            end
        end
    end

    // Sums over the up to four block texels.
    always_comb begin
        tx[0] = r_top_l; tx[1] = r_top_r; tx[2] = r_prev; tx[3] = r_cur;
        vld   = {1'b1, r_use_left, r_use_top, r_use_top & r_use_left};
        cnt   = 3'(vld[0]) + 3'(vld[1]) + 3'(vld[2]) + 3'(vld[3]);
        asum  = '0;
        for (int c = 0; c < 3; c++) begin
            psum[c] = '0;
            wsum[c] = '0;
        end
        for (int k = 0; k < 4; k++) begin
            if (vld[k]) begin
                asum = asum + 10'(tx[k][31:24]);
                for (int c = 0; c < 3; c++) begin
                    psum[c] = psum[c] + 10'(tx[k][8*c +: 8]);
                    wsum[c] = wsum[c] + (18'(tx[k][8*c +: 8]) * 18'(tx[k][31:24]));
                end
            end
        end
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.alpha_mode && asum != 10'd0) begin
                n_num[c] = 20'(wsum[c]);
                n_den[c] = 11'(asum);
            end else if (i_cmd.alpha_mode || 2'(c) <= i_cmd.nch_m1) begin
                n_num[c] = 20'(psum[c]);
                n_den[c] = 11'(cnt);
            end else begin
                n_num[c] = '0;
                n_den[c] = 11'd1;
            end
        end
        n_num[3] = i_cmd.alpha_mode ? 20'(asum) : '0;
        n_den[3] = 11'(cnt);
    end

    // Register the dividend/divisor so the sums settle before the dividers start.
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_num[c] <= n_num[c];
            r_den[c] <= n_den[c];
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_div
        awmd_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (i_cmd.start_div),
            .i_num   (r_num[g]),
            .i_den   (r_den[g]),
            .o_busy  (busy[g]),
            .o_quot  (o_res[g])
        );
    end

    assign o_sts.div_busy = |busy;
endmodule

// File: hdl/awmd_ctrl.sv
// Controller: configuration registers, source position and item sequencing.
// Depends on awmd_pkg.
`timescale 1ns / 1ps
module awmd_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [awmd_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [awmd_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_done,
    input  awmd_pkg::t_sts                  i_sts,
    output awmd_pkg::t_cmd                  o_cmd
);
    import awmd_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SUM, S_START, S_WAIT, S_OUT} t_state;

    t_state            r_state;
    logic [12:0]       r_w, r_h;
    logic [2:0]        r_nch;
    logic [ColW-1:0]   r_col;
    logic [RowW-1:0]   r_row;
    logic              r_done;
    logic [12:0]       w, h;
    logic [1:0]        nch_m1;
    logic              w1, h1, emit, done, acc, wrap_c;
    logic [12:0]       last_c, last_r;

    always_comb begin
        w = (r_w == 13'd0) ? 13'd1 : ((r_w > 13'(MaxWidth)) ? 13'(MaxWidth) : r_w);
        h = (r_h == 13'd0) ? 13'd1 : ((r_h > 13'(MaxHeight)) ? 13'(MaxHeight) : r_h);
        nch_m1 = (r_nch == 3'd0) ? 2'd0 : ((r_nch >= 3'd4) ? 2'd3 : 2'(r_nch - 3'd1));
        w1 = (w == 13'd1);
        h1 = (h == 13'd1);
        emit = (w1 || r_col[0]) && (h1 || r_row[0]);
        last_c = w1 ? 13'd0 : {w[12:1], 1'b0} - 13'd1;
        last_r = h1 ? 13'd0 : {h[12:1], 1'b0} - 13'd1;
        done = (13'(r_col) == last_c) && (13'(r_row) == last_r);
        wrap_c = (13'(r_col) + 13'd1) >= w;
        acc = i_valid && o_ready;
    end

    assign o_ready = (r_state == S_IDLE) && !i_cfg_we;
    assign o_valid = (r_state == S_OUT);
    assign o_done  = r_done;

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = acc;
        o_cmd.emit       = emit;
        o_cmd.use_top    = !h1;
        o_cmd.use_left   = !w1;
        o_cmd.done       = done;
        o_cmd.wr_store   = !h1 && !r_row[0];
        o_cmd.col        = r_col;
        o_cmd.clear      = i_cfg_we;
        o_cmd.start_div  = (r_state == S_START);
        o_cmd.alpha_mode = (nch_m1 == 2'd3);
        o_cmd.nch_m1     = nch_m1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_w     <= 13'd1;
            r_h     <= 13'd1;
            r_nch   <= 3'd4;
            r_col   <= '0;
            r_row   <= '0;
            r_done  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegSrcWidth:   r_w   <= i_cfg_data;
                RegSrcHeight:  r_h   <= i_cfg_data;
                RegChannelCnt: r_nch <= i_cfg_data[2:0];
                default: ;
            endcase
            if (i_cfg_idx == RegSrcWidth || i_cfg_idx == RegSrcHeight
                || i_cfg_idx == RegChannelCnt) begin
                r_col <= '0;
                r_row <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (wrap_c) begin
                            r_col <= '0;
                            r_row <= ((13'(r_row) + 13'd1) >= h) ? '0 : r_row + RowW'(1);
                        end else begin
                            r_col <= r_col + ColW'(1);
                        end
                        if (emit) begin
                            r_done  <= done;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM:   r_state <= S_START;
                S_START: r_state <= S_WAIT;
                S_WAIT: begin
                    if (!i_sts.div_busy) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hdl/alpha_weighted_mip_downsample.sv
// Alpha weighted 2x2 mip downsampler. A texel that closes no block leaves the
// controller idle and ready. A texel that closes a block offers its result
// after S_SUM forms the sums and operands, S_START starts the four bit-serial
// dividers, which run side by side, and S_WAIT waits out their 20 steps. The next
// texel is taken the cycle after the result transfer. Synchronous active-low
// reset clears position and sets width 1, height 1, four channels.
`timescale 1ns / 1ps
module alpha_weighted_mip_downsample (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [awmd_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [awmd_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  awmd_pkg::t_in_item              i_item,
    output logic                            o_valid,
    input  logic                            i_ready,
    output awmd_pkg::t_out_item             o_item
);
    import awmd_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic [7:0] res [4];
    logic       done;

    // The controller owns the geometry and the handshakes.
    awmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_done     (done),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the row store and the dividers; quotients stay
    // stable after the dividers finish until the next start.
    awmd_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_item),
        .o_sts   (sts),
        .o_res   (res)
    );

    assign o_item.out_red    = res[0];
    assign o_item.out_green  = res[1];
    assign o_item.out_blue   = res[2];
    assign o_item.out_alpha  = res[3];
    assign o_item.level_done = done;
endmodule

// File: verif/tb_top.sv
// Self-checking testbench for alpha_weighted_mip_downsample: random and directed texel
// streams over several geometries and channel modes, checked against an in-bench predictor.
// Depends on awmd_pkg and the block's RTL.
`timescale 1ns / 1ps

// Holds the state of the downsampler as seen from outside and the queue of
// reduced texels that are still to come.
class mip_scoreboard;
    logic [31:0] row_store [4096];
    logic [31:0] left_texel;
    int unsigned col;
    int unsigned row;
    int unsigned width;
    int unsigned height;
    int unsigned nch;
    awmd_pkg::t_out_item pending [$];
    int errors;

    function new();
        width = 1;
        height = 1;
        nch = 4;
        col = 0;
        row = 0;
        left_texel = '0;
        errors = 0;
    endfunction

    // A register write restarts the level.
    function void set_reg(logic [1:0] idx, logic [12:0] val);
        if (idx == awmd_pkg::RegSrcWidth) begin
            width = val;
        end else if (idx == awmd_pkg::RegSrcHeight) begin
            height = val;
        end else if (idx == awmd_pkg::RegChannelCnt) begin
            nch = val[2:0];
        end else begin
            return;
        end
        col = 0;
        row = 0;
        left_texel = '0;
    endfunction

    function int unsigned ch_of(logic [31:0] t, int c);
        return (t >> (8 * c)) & 32'hff;
    endfunction

    // Notes one accepted texel and queues the reduced texel it completes, if any.
    function void note_texel(awmd_pkg::t_in_item it);
        int unsigned w, h, ncl, ow, oh, n, asum, a, v;
        int unsigned wsum [3];
        int unsigned psum [3];
        int unsigned res [4];
        logic [31:0] cur;
        logic [31:0] blk [4];
        bit emit, done;
        awmd_pkg::t_out_item o;
        w = (width == 0) ? 1 : (width > 4096 ? 4096 : width);
        h = (height == 0) ? 1 : (height > 4096 ? 4096 : height);
        ncl = (nch == 0) ? 1 : (nch > 4 ? 4 : nch);
        cur = {it.alpha, it.blue, it.green, it.red};
        n = 0;
        done = 0;
        emit = (w == 1) ? 1 : col[0];
        if (h != 1 && !row[0]) emit = 0;
        if (emit) begin
            if (h != 1) begin
                if (w != 1) begin
                    blk[n] = row_store[col - 1];
                    n++;
                end
                blk[n] = row_store[col];
                n++;
            end
            if (w != 1) begin
                blk[n] = left_texel;
                n++;
            end
            blk[n] = cur;
            n++;
            ow = (w / 2 == 0) ? 1 : w / 2;
            oh = (h / 2 == 0) ? 1 : h / 2;
            done = (col == (w == 1 ? 0 : 2 * ow - 1)) && (row == (h == 1 ? 0 : 2 * oh - 1));
        end
        if (h != 1 && !row[0]) row_store[col] = cur;
        left_texel = cur;
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        if (!emit) return;
        res = '{0, 0, 0, 0};
        if (ncl == 4) begin
            asum = 0;
            wsum = '{0, 0, 0};
            psum = '{0, 0, 0};
            for (int k = 0; k < n; k++) begin
                a = ch_of(blk[k], 3);
                asum += a;
                for (int c = 0; c < 3; c++) begin
                    v = ch_of(blk[k], c);
                    wsum[c] += v * a;
                    psum[c] += v;
                end
            end
            for (int c = 0; c < 3; c++) res[c] = asum > 0 ? wsum[c] / asum : psum[c] / n;
            res[3] = asum / n;
        end else begin
            for (int c = 0; c < ncl; c++) begin
                v = 0;
                for (int k = 0; k < n; k++) v += ch_of(blk[k], c);
                res[c] = v / n;
            end
        end
        o.out_red = res[0][7:0];
        o.out_green = res[1][7:0];
        o.out_blue = res[2][7:0];
        o.out_alpha = res[3][7:0];
        o.level_done = done;
        pending = {pending, o};
    endfunction

    // Compares one delivered reduced texel with the oldest one pending.
    function void check_texel(awmd_pkg::t_out_item got);
        awmd_pkg::t_out_item exp;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.out_red !== exp.out_red)
            $display("%0t: out_red expected %0d actual %0d", $time, exp.out_red, got.out_red);
        if (got.out_green !== exp.out_green)
            $display("%0t: out_green expected %0d actual %0d", $time, exp.out_green,
                     got.out_green);
        if (got.out_blue !== exp.out_blue)
            $display("%0t: out_blue expected %0d actual %0d", $time, exp.out_blue, got.out_blue);
        if (got.out_alpha !== exp.out_alpha)
            $display("%0t: out_alpha expected %0d actual %0d", $time, exp.out_alpha,
                     got.out_alpha);
        if (got.level_done !== exp.level_done)
            $display("%0t: level_done expected %0d actual %0d", $time, exp.level_done,
                     got.level_done);
        if (got !== exp) errors++;
    endfunction
endclass

module tb_top;
    import awmd_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    t_in_item            i_item = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    t_out_item           o_item;

    mip_scoreboard sb = new();

    // Receiver behavior is steered from the stimulus process through these.
    bit sink_idles = 1'b1;
    bit sink_hold = 1'b0;
    // Sender idling is turned off for the last part of the run.
    bit source_idles = 1'b1;
    int texels_sent = 0;

    always #6 i_clk = ~i_clk;

    alpha_weighted_mip_downsample uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

    // Every output transfer is checked at the edge where it happens.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_texel(o_item);
    end

    // Receiver: random stall bursts, or none, or a long hold-off on request.
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (sink_hold) begin
                i_ready <= 1'b0;
                @(posedge i_clk);
            end else if (sink_idles && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 13);
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Writes one register; callers drain the block first so it is idle. The predictor follows.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one texel and holds it until the block takes it.
    task automatic send_texel(t_in_item it);
        if (source_idles && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_texel(it);
        texels_sent++;
    endtask

    function automatic t_in_item rand_texel();
        t_in_item it;
        it = $urandom();
        // Often give zero or full alpha so both weighting paths get exercised.
        case ($urandom_range(0, 5))
            0: it.alpha = 8'h00;
            1: it.alpha = 8'hff;
            default: ;
        endcase
        return it;
    endfunction

    // Waits until every pending result has come, then lets the divider drain.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Sends a given number of whole source levels of the current geometry.
    // A zero dimension acts as one.
    task automatic send_levels(int levels);
        for (int l = 0; l < levels; l++)
            for (int k = 0; k < (sb.width == 0 ? 1 : sb.width) *
                                (sb.height == 0 ? 1 : sb.height); k++)
                send_texel(rand_texel());
    endtask

    task automatic set_geometry(int w, int h, int c);
        write_reg(RegSrcWidth, w[12:0]);
        write_reg(RegSrcHeight, h[12:0]);
        write_reg(RegChannelCnt, c[12:0]);
    endtask

    initial begin
        t_in_item it;
        int w, h;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset geometry is 1x1 with four channels; extremes of texels.
        send_texel('0);
        send_texel('1);
        send_texel(32'hff00_ff00);
        send_texel(32'h00ff_00ff);
        // A 2x2 block with all alpha zero falls back to a plain average,
        // and one with a single lit texel takes that texel's colour.
        drain();
        set_geometry(2, 2, 4);
        for (int k = 0; k < 4; k++) send_texel({8'(k * 60), 8'(255 - k), 8'(k), 8'h00});
        for (int k = 0; k < 4; k++) send_texel({8'hc8, 8'h11, 8'h77, (k == 3) ? 8'hff : 8'h00});
        // Odd width and height drop the last column and row; width 1 and height 1.
        drain();
        set_geometry(3, 3, 1);
        send_levels(1);
        drain();
        set_geometry(1, 2, 2);
        send_levels(1);
        drain();
        set_geometry(2, 1, 3);
        send_levels(1);
        // Out of range values: zero acts as one, large counts clamp.
        drain();
        set_geometry(0, 0, 0);
        send_levels(1);
        drain();
        set_geometry(2, 2, 7);
        send_levels(1);
        // A wide level over two rows, then oversized values that clamp.
        drain();
        set_geometry(300, 2, 4);
        send_levels(1);
        drain();
        set_geometry(8191, 1, 4);
        for (int k = 0; k < 16; k++) send_texel(rand_texel());
        drain();
        set_geometry(2, 8191, 4);
        for (int k = 0; k < 16; k++) send_texel(rand_texel());

        // Long receiver hold-off while the sender keeps offering texels.
        drain();
        set_geometry(4, 4, 4);
        sink_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            send_levels(2);
        join

        // Random phases with small geometries and assorted channel counts.
        while (texels_sent < 1950) begin
            drain();
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 9);
            h = $urandom_range(0, 8);
            set_geometry(w, h, $urandom_range(0, 7));
            if (texels_sent > 1500) begin
                sink_idles = 1'b0;
                source_idles = 1'b0;
            end
            repeat ($urandom_range(1, 3)) send_levels(1);
            // Part of a level, ended by the next register write.
            for (int k = $urandom_range(0, 6); k > 0; k--) send_texel(rand_texel());
        end

        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard limit on run time.
    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
